// ===== hdl/polynomial_benchmark_fitness_top_defines.svh =====
// Assertion macros shared by the fitness accumulator RTL.
// Taken in by the top level; no other dependencies.
`ifndef POLYNOMIAL_BENCHMARK_FITNESS_TOP_DEFINES_SVH
`define POLYNOMIAL_BENCHMARK_FITNESS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Concurrent property check on a clock with an active-low reset
`define PBF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next
`define PBF_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define PBF_ASSERT(label, clk, rst_n, prop, msg)
`define PBF_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg)
`endif
`endif

// ===== hdl/pbf_pkg.sv =====
// Shared types, widths and codes for the polynomial benchmark fitness block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pbf_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int MODE_W     = 2;
    localparam int FIT_W      = 63;
    localparam int M_TDATA_W  = 64;

    // Internal arithmetic widths
    localparam int PREFIX_W   = 23;
    localparam int OP_W       = 31;
    localparam int PROD_W     = 2 * OP_W;
    localparam int TERM_W     = 56;
    localparam int FRAC_W     = 16;
    localparam int COORD_FRAC = 8;
    localparam int SQ16_W     = 31;
    localparam int DIFF_W     = 32;
    localparam int C4_W       = 61;
    localparam int QRT_BASE_W = C4_W - FRAC_W;
    localparam int ROS_WT_W   = 7;
    localparam int SCALE_W    = PROD_W + ROS_WT_W;
    localparam int OFS_W      = COORD_W + 1;
    localparam int OFS_SQ_W   = 32;

    localparam int MAX_ELEMENTS_DEF = 64;

    localparam logic [ROS_WT_W-1:0] ROS_WEIGHT = 7'd100;
    localparam logic [OFS_W-1:0]    ROS_ONE    = 17'd256;
    localparam logic [FIT_W-1:0]    FIT_MAX    = {FIT_W{1'b1}};
    localparam logic [PREFIX_W-1:0] PREFIX_MAX = {1'b0, {(PREFIX_W-1){1'b1}}};
    localparam logic [PREFIX_W-1:0] PREFIX_MIN = {1'b1, {(PREFIX_W-1){1'b0}}};

    // Function select codes
    localparam logic [MODE_W-1:0] FN_SPHERE     = 2'd0;
    localparam logic [MODE_W-1:0] FN_SCHWEFEL   = 2'd1;
    localparam logic [MODE_W-1:0] FN_ROSENBROCK = 2'd2;
    localparam logic [MODE_W-1:0] FN_QUARTIC    = 2'd3;

    // Datapath step codes
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_NONE       = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_TERM   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_PROD   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_OPS    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ROS_DIFF   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ROS_OFFSET = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ROS_SCALE  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_ROS_SUM    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_QRT_WEIGHT = 4'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              add_term;
        logic              finish;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              in_range;
        logic              have_prev;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/pbf_ctrl.sv =====
// Sequencing state machine for the fitness accumulator.
// Depends on pbf_pkg; drives the datapath by dp_cmd_t, reads dp_status_t.
`timescale 1ns / 1ps
`default_nettype none

module pbf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tlast,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  pbf_pkg::dp_status_t     status,
    output pbf_pkg::dp_cmd_t        cmd
);
    import pbf_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [ST_W-1:0] ST_MUL1       = 4'd1;
    localparam logic [ST_W-1:0] ST_ROS_DIFF   = 4'd2;
    localparam logic [ST_W-1:0] ST_ROS_OFFSET = 4'd3;
    localparam logic [ST_W-1:0] ST_ROS_SCALE  = 4'd4;
    localparam logic [ST_W-1:0] ST_ROS_SUM    = 4'd5;
    localparam logic [ST_W-1:0] ST_QRT_SQ     = 4'd6;
    localparam logic [ST_W-1:0] ST_QRT_WEIGHT = 4'd7;
    localparam logic [ST_W-1:0] ST_FINISH     = 4'd8;

    logic [ST_W-1:0] state_reg, state_next;
    logic            last_reg, last_next;
    logic            pend_reg, pend_next;
    logic            m_tvalid_reg, m_tvalid_next;

    assign m_tvalid = m_tvalid_reg;

    // Next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.step      = STEP_NONE;
        case (state_reg)
            ST_IDLE: begin
                // fold the previous word's term in while waiting
                s_tready     = 1'b1;
                cmd.add_term = pend_reg;
                pend_next    = 1'b0;
                if (s_tvalid) begin
                    cmd.load  = 1'b1;
                    last_next = s_tlast;
                    if (!status.in_range ||
                        (status.mode == FN_ROSENBROCK && !status.have_prev)) begin
                        state_next = s_tlast ? ST_FINISH : ST_IDLE;
                    end else begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                if (status.mode == FN_ROSENBROCK) begin
                    cmd.step   = STEP_MUL_PROD;
                    state_next = ST_ROS_DIFF;
                end else if (status.mode == FN_QUARTIC) begin
                    cmd.step   = STEP_MUL_OPS;
                    state_next = ST_QRT_SQ;
                end else begin
                    cmd.step   = STEP_MUL_TERM;
                    pend_next  = 1'b1;
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_ROS_DIFF: begin
                cmd.step   = STEP_ROS_DIFF;
                state_next = ST_ROS_OFFSET;
            end
            ST_ROS_OFFSET: begin
                cmd.step   = STEP_ROS_OFFSET;
                state_next = ST_ROS_SCALE;
            end
            ST_ROS_SCALE: begin
                cmd.step   = STEP_ROS_SCALE;
                state_next = ST_ROS_SUM;
            end
            ST_ROS_SUM: begin
                cmd.step   = STEP_ROS_SUM;
                pend_next  = 1'b1;
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_QRT_SQ: begin
                cmd.step   = STEP_MUL_PROD;
                state_next = ST_QRT_WEIGHT;
            end
            ST_QRT_WEIGHT: begin
                cmd.step   = STEP_QRT_WEIGHT;
                pend_next  = 1'b1;
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    cmd.add_term  = pend_reg;
                    pend_next     = 1'b0;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pbf_datapath.sv =====
// Datapath of the fitness accumulator: running state, shared squarer, term
// builder, saturating accumulator and result register. Depends on pbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbf_datapath #(
    parameter int MAX_ELEMENTS = pbf_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [pbf_pkg::MODE_W-1:0]  cfg_wr_data,
    input  wire logic [pbf_pkg::COORD_W-1:0] coordinate,
    input  pbf_pkg::dp_cmd_t                 cmd,
    output pbf_pkg::dp_status_t              status,
    output logic [pbf_pkg::FIT_W-1:0]        fitness,
    output logic                             overflow
);
    import pbf_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS + 1);
    localparam int QRT_W = QRT_BASE_W + IDX_W;

    // Vector state
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [FIT_W-1:0]    acc_reg, acc_next;
    logic                sat_reg, sat_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic [COORD_W-1:0]  prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // Working registers
    logic [OP_W-1:0]     ops_reg, ops_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TERM_W-1:0]   term_reg, term_next;
    logic [COORD_W-1:0]  coord_reg, coord_next;
    logic [COORD_W-1:0]  pair_reg, pair_next;
    logic [IDX_W-1:0]    weight_reg, weight_next;
    logic [FIT_W-1:0]    fitness_reg, fitness_next;
    logic                overflow_reg, overflow_next;

    // Arithmetic
    logic                in_range;
    logic [PREFIX_W:0]   prefix_sum;
    logic [PREFIX_W-1:0] prefix_sat;
    logic [PREFIX_W-1:0] prefix_mag;
    logic [COORD_W:0]    coord_mag;
    logic [COORD_W:0]    prev_mag;
    logic [PROD_W-1:0]   mul_out;
    logic [DIFF_W-1:0]   ros_diff;
    logic [DIFF_W-1:0]   ros_mag;
    logic [OFS_W-1:0]    ros_ofs;
    logic [OFS_W-1:0]    ofs_mag;
    logic [SCALE_W-1:0]  ros_scaled;
    logic [QRT_W-1:0]    qrt_prod;
    logic [TERM_W-1:0]   term_add;
    logic [FIT_W:0]      acc_sum;
    logic [FIT_W-1:0]    acc_new;
    logic                sat_new;

    assign in_range = idx_reg < IDX_W'(MAX_ELEMENTS);

    assign status.mode      = mode_reg;
    assign status.in_range  = in_range;
    assign status.have_prev = have_prev_reg;

    assign fitness  = fitness_reg;
    assign overflow = overflow_reg;

    // Running prefix, clamped to its signed range
    assign prefix_sum = {prefix_reg[PREFIX_W-1], prefix_reg}
                      + {{(PREFIX_W+1-COORD_W){coordinate[COORD_W-1]}}, coordinate};
    always_comb begin
        if (prefix_sum[PREFIX_W] != prefix_sum[PREFIX_W-1]) begin
            prefix_sat = prefix_sum[PREFIX_W] ? PREFIX_MIN : PREFIX_MAX;
        end else begin
            prefix_sat = prefix_sum[PREFIX_W-1:0];
        end
    end

    // Magnitudes of the operands to square
    assign prefix_mag = prefix_sat[PREFIX_W-1] ? (~prefix_sat + 1'b1) : prefix_sat;
    assign coord_mag  = coordinate[COORD_W-1] ? (~{1'b1, coordinate} + 1'b1)
                                              : {1'b0, coordinate};
    assign prev_mag   = prev_reg[COORD_W-1] ? (~{1'b1, prev_reg} + 1'b1)
                                            : {1'b0, prev_reg};

    // Shared squarer
    assign mul_out = {{(PROD_W-OP_W){1'b0}}, ops_reg} * {{(PROD_W-OP_W){1'b0}}, ops_reg};

    // Rosenbrock: p^2 - x*256, then (p - 1.0)
    assign ros_diff = {{(DIFF_W-SQ16_W){1'b0}}, prod_reg[SQ16_W-1:0]}
                    - {{(DIFF_W-COORD_W-COORD_FRAC){coord_reg[COORD_W-1]}}, coord_reg,
                       {COORD_FRAC{1'b0}}};
    assign ros_mag  = ros_diff[DIFF_W-1] ? (~ros_diff + 1'b1) : ros_diff;
    assign ros_ofs  = {pair_reg[COORD_W-1], pair_reg} - ROS_ONE;
    assign ofs_mag  = ros_ofs[OFS_W-1] ? (~ros_ofs + 1'b1) : ros_ofs;
    assign ros_scaled = {{ROS_WT_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, ROS_WEIGHT};

    // Quartic: floor(x^4 / 2^16) times the element weight
    assign qrt_prod = QRT_W'(prod_reg[C4_W-1:FRAC_W]) * QRT_W'(weight_reg);

    // Saturating accumulate
    assign term_add = cmd.add_term ? term_reg : '0;
    assign acc_sum  = {1'b0, acc_reg} + {{(FIT_W+1-TERM_W){1'b0}}, term_add};
    assign acc_new  = acc_sum[FIT_W] ? FIT_MAX : acc_sum[FIT_W-1:0];
    assign sat_new  = sat_reg | acc_sum[FIT_W];

    // Vector state update
    always_comb begin
        mode_next      = mode_reg;
        acc_next       = acc_new;
        sat_next       = sat_new;
        prefix_next    = prefix_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        idx_next       = idx_reg;
        if (cfg_wr_en) begin
            mode_next = cfg_wr_data;
        end
        if (cmd.load && in_range) begin
            prefix_next    = prefix_sat;
            prev_next      = coordinate;
            have_prev_next = 1'b1;
            idx_next       = idx_reg + IDX_W'(1);
        end
        if (cmd.finish) begin
            acc_next       = '0;
            sat_next       = 1'b0;
            prefix_next    = '0;
            prev_next      = '0;
            have_prev_next = 1'b0;
            idx_next       = '0;
        end
    end

    // Working register update
    always_comb begin
        ops_next      = ops_reg;
        prod_next     = prod_reg;
        term_next     = term_reg;
        coord_next    = coord_reg;
        pair_next     = pair_reg;
        weight_next   = weight_reg;
        fitness_next  = fitness_reg;
        overflow_next = overflow_reg;
        if (cmd.load) begin
            coord_next  = coordinate;
            pair_next   = prev_reg;
            weight_next = idx_reg + IDX_W'(1);
            case (mode_reg)
                FN_SCHWEFEL:   ops_next = OP_W'(prefix_mag);
                FN_ROSENBROCK: ops_next = OP_W'(prev_mag);
                default:       ops_next = OP_W'(coord_mag);
            endcase
        end
        case (cmd.step)
            STEP_MUL_TERM: begin
                term_next = TERM_W'(mul_out);
            end
            STEP_MUL_PROD: begin
                prod_next = mul_out;
            end
            STEP_MUL_OPS: begin
                ops_next = mul_out[OP_W-1:0];
            end
            STEP_ROS_DIFF: begin
                ops_next = ros_mag[OP_W-1:0];
            end
            STEP_ROS_OFFSET: begin
                prod_next = mul_out;
                ops_next  = OP_W'(ofs_mag);
            end
            STEP_ROS_SCALE: begin
                term_next = TERM_W'(ros_scaled[SCALE_W-1:FRAC_W]);
                prod_next = mul_out;
            end
            STEP_ROS_SUM: begin
                term_next = term_reg + TERM_W'(prod_reg[OFS_SQ_W-1:0]);
            end
            STEP_QRT_WEIGHT: begin
                term_next = TERM_W'(qrt_prod);
            end
            default: begin
                term_next = term_reg;
            end
        endcase
        if (cmd.finish) begin
            fitness_next  = acc_new;
            overflow_next = sat_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= FN_SPHERE;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            prefix_reg    <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            prefix_reg    <= prefix_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ops_reg      <= ops_next;
        prod_reg     <= prod_next;
        term_reg     <= term_next;
        coord_reg    <= coord_next;
        pair_reg     <= pair_next;
        weight_reg   <= weight_next;
        fitness_reg  <= fitness_next;
        overflow_reg <= overflow_next;
    end

endmodule

`default_nettype wire

// ===== hdl/polynomial_benchmark_fitness_top.sv =====
// Polynomial benchmark fitness accumulator: usage notes.
// Input stream: one signed Q7.8 coordinate per word on s_tdata, s_tlast on
// the final element of a vector. Output stream: one word per vector, the
// unsigned Q47.16 fitness on m_tdata and the saturation flag on m_tuser.
// cfg_wr_en / cfg_wr_data write the function select (0 sphere, 1 Schwefel
// 1.2, 2 Rosenbrock, 3 weighted quartic); write it only between words.
// A word is taken only once the previous word's term is built, since each
// term walks through the single shared squarer step by step; the first
// Rosenbrock element and elements beyond MAX_ELEMENTS build no term. The
// result of a vector is loaded into the output register in the finish
// state that follows the last element's term, once the register is free.
// The output register lets the next vector's words be taken while a result
// waits; a stalled receiver only holds the end of the following vector.
// Reset (aresetn low, synchronous) clears the running totals, the select
// register and the output valid.
// Depends on pbf_pkg, pbf_ctrl, pbf_datapath and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "polynomial_benchmark_fitness_top_defines.svh"

module polynomial_benchmark_fitness_top #(
    parameter int MAX_ELEMENTS = pbf_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pbf_pkg::MODE_W-1:0]    cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pbf_pkg::COORD_W-1:0]   s_tdata,   // [15:0] coordinate
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pbf_pkg::M_TDATA_W-1:0]      m_tdata,   // [62:0] fitness, [63] zero
    output logic                               m_tuser    // [0] overflow
);
    import pbf_pkg::*;

    dp_cmd_t              dp_cmd;
    dp_status_t           dp_status;
    logic [FIT_W-1:0]     fitness;
    logic                 overflow;

    pbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    pbf_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .coordinate  (s_tdata),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .fitness     (fitness),
        .overflow    (overflow)
    );

    // Pack the result word
    assign m_tdata = {{(M_TDATA_W-FIT_W){1'b0}}, fitness};
    assign m_tuser = overflow;

    // Result register is only loaded when it is empty or being drained
    `PBF_ASSERT(a_finish_slot, aclk, aresetn, dp_cmd.finish |-> (!m_tvalid || m_tready), "result loaded over a pending word")
    // A vector is closed only while no new word enters
    `PBF_ASSERT(a_no_load_on_finish, aclk, aresetn, dp_cmd.finish |-> !(s_tvalid && s_tready), "word accepted while closing a vector")
    // Closing a vector presents its result next cycle
    `PBF_ASSERT_NEXT(a_result_follows, aclk, aresetn, dp_cmd.finish, m_tvalid, "result not presented after close")
    // Output valid rises only from a vector close
    `PBF_ASSERT(a_result_source, aclk, aresetn, $rose(m_tvalid) |-> $past(dp_cmd.finish), "output valid without a vector close")

endmodule

`default_nettype wire
